>>> hw/rtl/base64_decoder_defines.svh
// ----------------------------------------------------------------------------
// base64 decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH

// checked only while out of reset
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// types, character codes and the sextet lookup of the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } b64d_sextet_t;

  // one queue entry: the bytes of a finished quad or a failure report
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  nbytes;
    logic        last;
    logic        fail;
  } b64d_entry_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
    b64d_sextet_t s;
    logic [7:0]   d;
    s.bad   = 1'b0;
    s.value = '0;
    d       = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d       = c - CHAR_UPPER_A;
      s.value = d[5:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d       = c - CHAR_LOWER_A;
      s.value = d[5:0] + SEXTET_LOWER_BASE;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d       = c - CHAR_DIGIT_0;
      s.value = d[5:0] + SEXTET_DIGIT_BASE;
    end else if (c == CHAR_PLUS) begin
      s.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s.value = SEXTET_SLASH;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// takes characters, gathers sextets into quads, checks padding and errors
// ----------------------------------------------------------------------------
`include "base64_decoder_defines.svh"

module b64d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  input  logic                 full_i,
  output logic                 wr_en_o,
  output b64d_pkg::b64d_entry_t wr_data_o
);
  import b64d_pkg::*;

  logic [1:0]   pos_r,  pos_nxt;
  logic [17:0]  acc_r,  acc_nxt;
  logic         pad3_r, pad3_nxt;
  logic         err_r,  err_nxt;
  logic         accept;
  logic         is_pad;
  b64d_sextet_t sx;
  logic [5:0]   v;
  logic [1:0]   nb;

  assign accept = push_i && !full_i;
  assign is_pad = (char_i == CHAR_PAD);
  assign sx     = sextet_of(char_i);
  assign v      = is_pad ? 6'd0 : sx.value;

  always_comb begin
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    pad3_nxt = pad3_r;
    err_nxt  = err_r;
    nb       = 2'd0;
    if (!err_r) begin
      if (!is_pad && sx.bad) begin
        err_nxt = 1'b1;
      end else if (is_pad && pos_r < 2'd2) begin
        err_nxt = 1'b1;
      end else if (pos_r != 2'd3) begin
        if (pos_r == 2'd2 && is_pad) begin
          pad3_nxt = 1'b1;
        end
        acc_nxt = {acc_r[11:0], v};
        pos_nxt = pos_r + 2'd1;
      end else if (pad3_r && !is_pad) begin
        err_nxt = 1'b1;
      end else if ((pad3_r || is_pad) && !last_i) begin
        err_nxt = 1'b1;
      end else begin
        nb       = 2'd1 + {1'b0, !pad3_r} + {1'b0, !is_pad};
        pos_nxt  = 2'd0;
        acc_nxt  = '0;
        pad3_nxt = 1'b0;
      end
      if (!err_nxt && last_i && pos_nxt != 2'd0) begin
        err_nxt = 1'b1;
      end
    end
  end

  assign wr_data_o.triple = {acc_r, v};
  assign wr_data_o.fail   = last_i && err_nxt;
  assign wr_data_o.nbytes = wr_data_o.fail ? 2'd0 : nb;
  assign wr_data_o.last   = last_i;
  assign wr_en_o          = accept && (last_i || nb != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      pad3_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        pos_r  <= '0;
        acc_r  <= '0;
        pad3_r <= 1'b0;
        err_r  <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        acc_r  <= acc_nxt;
        pad3_r <= pad3_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // a text end always leaves a clean quad state
  `B64D_ASSERT(a_clean_after_last, $past(accept && last_i) |-> (pos_r == 2'd0 && !err_r && !pad3_r), "state not cleared after last character")

endmodule

>>> hw/rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// short entry queue between the quad front and the byte back end
// ----------------------------------------------------------------------------
`include "base64_decoder_defines.svh"

module b64d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en_i,
  input  b64d_pkg::b64d_entry_t wr_data_i,
  input  logic                  rd_en_i,
  output b64d_pkg::b64d_entry_t rd_data_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import b64d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             do_wr, do_rd;

  assign empty_o   = (cnt_r == '0);
  assign full_o    = (cnt_r == CNT_W'(DEPTH));
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data_i;
    end
  end

  `B64D_ASSERT_ALWAYS(a_fifo_reset, $past(!rst_n) |-> (cnt_r == '0 && rd_ptr_r == wr_ptr_r), "queue not empty after reset")
  `B64D_ASSERT(a_fifo_bound, cnt_r <= CNT_W'(DEPTH), "queue count above depth")

endmodule

>>> hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// walks queue entries byte by byte into the registered result stage
// ----------------------------------------------------------------------------
`include "base64_decoder_defines.svh"

module b64d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64d_pkg::b64d_entry_t head_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [7:0]            data_byte_o,
  output logic                  byte_valid_o,
  output logic                  run_last_o,
  output logic                  text_done_o,
  output logic                  failed_o
);
  import b64d_pkg::*;

  logic [1:0] sel_r;
  logic       out_vld_r;
  logic [7:0] byte_r;
  logic       bvalid_r, rlast_r, done_r, fail_r;
  logic       load;
  logic       final_beat;
  logic [7:0] cur_byte;

  assign load       = !q_empty_i && (!out_vld_r || pop_i);
  assign final_beat = head_i.fail || (sel_r == head_i.nbytes - 2'd1);
  assign q_pop_o    = load && final_beat;

  always_comb begin
    case (sel_r)
      2'd0:    cur_byte = head_i.triple[23:16];
      2'd1:    cur_byte = head_i.triple[15:8];
      default: cur_byte = head_i.triple[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        sel_r     <= final_beat ? 2'd0 : sel_r + 2'd1;
      end else if (pop_i) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head_i.fail ? 8'd0 : cur_byte;
      bvalid_r <= !head_i.fail;
      rlast_r  <= final_beat;
      done_r   <= final_beat && head_i.last;
      fail_r   <= head_i.fail;
    end
  end

  assign empty_o      = !out_vld_r;
  assign data_byte_o  = byte_r;
  assign byte_valid_o = bvalid_r;
  assign run_last_o   = rlast_r;
  assign text_done_o  = done_r;
  assign failed_o     = fail_r;

  // partway through an entry the entry is still at the queue head
  `B64D_ASSERT(a_mid_entry_held, (sel_r != 2'd0) |-> (!q_empty_i && !head_i.fail && sel_r < head_i.nbytes), "byte index outside the head entry")

endmodule

>>> hw/rtl/base64_decoder.sv
// ----------------------------------------------------------------------------
// base64_decoder
// streaming base64 text decoder, one character in per beat
// ----------------------------------------------------------------------------
// Input: one character per beat on in_text_char, with in_text_last marking
// the final character of a text; a beat is taken when in_push is high and
// in_full is low.
// Output: result beats behave as a queue read side; the oldest result sits
// on the out_ ports while out_empty is low and leaves on out_pop.
// Each finished quad gives one to three byte beats; the last character
// gives the text_done beat (on the final byte, or a failure beat alone).
// The first result of a character passes through the entry queue and then
// the output register, which it enters when the output register is free.
// Throughput: one character per cycle in while in_full is low, and one result
// beat per cycle out while out_pop stays high; a three-byte quad gives three
// output beats, and the entry queue of QUEUE_DEPTH entries absorbs the burst.
// When the receiver stalls, results wait in the output register and queue;
// in_full rises once the queue holds QUEUE_DEPTH entries.
// Reset clears the quad state, the queue and the output register.
// ----------------------------------------------------------------------------
module base64_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_text_char,
  input  logic       in_text_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_text_done,
  output logic       out_failed
);
  import b64d_pkg::*;

  logic        q_wr, q_rd, q_empty, q_full;
  b64d_entry_t q_wdata, q_head;

  assign in_full = q_full;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (in_push),
    .char_i    (in_text_char),
    .last_i    (in_text_last),
    .full_i    (q_full),
    .wr_en_o   (q_wr),
    .wr_data_o (q_wdata)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en_i   (q_wr),
    .wr_data_i (q_wdata),
    .rd_en_i   (q_rd),
    .rd_data_o (q_head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (q_head),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_rd),
    .pop_i        (out_pop),
    .empty_o      (out_empty),
    .data_byte_o  (out_data_byte),
    .byte_valid_o (out_byte_valid),
    .run_last_o   (out_run_last),
    .text_done_o  (out_text_done),
    .failed_o     (out_failed)
  );

endmodule

>>> tb/tb_base64_decoder.sv
// ----------------------------------------------------------------------------
// tb_base64_decoder
// Streams base64 text into the decoder and checks every result beat, field
// by field, against a cycle-free model of the decoder kept in the bench.
// A short table of directed characters comes first. It covers the extremes,
// the padding forms and each error rule, with some results typed in by hand.
// Random texts follow: mostly well-formed, some broken, some raw noise.
// Both sides stall in random bursts, and the reader holds off once long
// enough to fill the decoder.
// ----------------------------------------------------------------------------
module tb_base64_decoder;
  import b64d_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_CHARS = 170;
  localparam int CALM_AFTER   = 145;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
    logic       failed;
  } beat_t;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_QUIET, ROW_ONE} row_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    row_kind_t  kind;
    beat_t      beat;
  } char_row_t;

  localparam beat_t FAIL_BEAT = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
  localparam beat_t NO_BEAT   = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_text_char;
  logic       in_text_last;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_run_last;
  logic       out_text_done;
  logic       out_failed;

  base64_decoder DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_text_char  (in_text_char),
    .in_text_last  (in_text_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data_byte (out_data_byte),
    .out_byte_valid(out_byte_valid),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done),
    .out_failed    (out_failed)
  );

  // decoder model state
  logic [1:0]  quad_pos;
  logic [17:0] sextet_acc;
  logic        third_is_pad;
  logic        text_error;

  beat_t     expected_beats[$];
  char_row_t directed_rows[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        chars_sent;
  bit        calm;
  bit        hold_request;
  bit        sender_idles;
  beat_t     head_beat;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] alphabet_char(input int v);
    logic [7:0] c;
    if (v < 26) c = CHAR_UPPER_A + 8'(v);
    else if (v < 52) c = CHAR_LOWER_A + 8'(v - 26);
    else if (v < 62) c = CHAR_DIGIT_0 + 8'(v - 52);
    else if (v == 62) c = CHAR_PLUS;
    else c = CHAR_SLASH;
    return c;
  endfunction

  function automatic void queue_beat(input beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // advance the model by one character; results go to the scoreboard if keep
  task automatic decode_step(input logic [7:0] c, input logic last, input bit keep);
    logic [7:0]  d;
    logic [5:0]  v;
    logic        bad;
    logic        is_pad;
    logic [23:0] triple;
    logic [7:0]  bytes_out[3];
    int          nb;
    beat_t       b;
    nb     = 0;
    bad    = 1'b0;
    v      = '0;
    d      = '0;
    is_pad = (c == CHAR_PAD);
    if (!text_error) begin
      if (is_pad) v = '0;
      else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
        d = c - CHAR_UPPER_A;
        v = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
        d = c - CHAR_LOWER_A + 8'd26;
        v = d[5:0];
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
        d = c - CHAR_DIGIT_0 + 8'd52;
        v = d[5:0];
      end else if (c == CHAR_PLUS) v = 6'd62;
      else if (c == CHAR_SLASH) v = 6'd63;
      else bad = 1'b1;

      if (bad) text_error = 1'b1;
      else if (is_pad && quad_pos < 2'd2) text_error = 1'b1;
      else if (quad_pos < 2'd3) begin
        if (quad_pos == 2'd2 && is_pad) third_is_pad = 1'b1;
        sextet_acc = {sextet_acc[11:0], v};
        quad_pos   = quad_pos + 2'd1;
      end else begin
        if (third_is_pad && !is_pad) text_error = 1'b1;
        else if ((third_is_pad || is_pad) && !last) text_error = 1'b1;
        else begin
          triple = {sextet_acc, v};
          bytes_out[nb] = triple[23:16];
          nb++;
          if (!third_is_pad) begin
            bytes_out[nb] = triple[15:8];
            nb++;
          end
          if (!is_pad) begin
            bytes_out[nb] = triple[7:0];
            nb++;
          end
          quad_pos     = '0;
          sextet_acc   = '0;
          third_is_pad = 1'b0;
        end
      end
      if (!text_error && last && quad_pos != 2'd0) text_error = 1'b1;
    end

    if (last && text_error) nb = 0;
    for (int i = 0; i < nb; i++) begin
      b.data_byte  = bytes_out[i];
      b.byte_valid = 1'b1;
      b.run_last   = (i == nb - 1);
      b.text_done  = (i == nb - 1) && last;
      b.failed     = 1'b0;
      if (keep) queue_beat(b);
    end
    if (last && nb == 0 && keep) queue_beat(FAIL_BEAT);
    if (last) begin
      quad_pos     = '0;
      sextet_acc   = '0;
      third_is_pad = 1'b0;
      text_error   = 1'b0;
    end
  endtask

  // returns at the edge that takes the beat
  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    if (sender_idles && !calm && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_push      <= 1'b1;
    in_text_char <= c;
    in_text_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
      decode_step(text[i], i == text.size() - 1, 1'b1);
    end
  endtask

  task automatic send_random_text();
    logic [7:0] text[$];
    int         mode;
    int         nquads;
    int         npad;
    int         pos;
    int         drop;
    mode         = $urandom_range(0, 9);
    sender_idles = ($urandom_range(0, 2) != 0);
    if (mode == 9) begin
      repeat ($urandom_range(1, 8)) text.insert(text.size(), 8'($urandom_range(0, 255)));
    end else begin
      nquads = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      repeat (4 * nquads) text.insert(text.size(), alphabet_char($urandom_range(0, 63)));
      npad = $urandom_range(0, 2);
      if (npad >= 1) text[text.size() - 1] = CHAR_PAD;
      if (npad == 2) text[text.size() - 2] = CHAR_PAD;
      pos = $urandom_range(0, text.size() - 1);
      case (mode)
        6: text[pos] = 8'($urandom_range(0, 255));
        7: text[pos] = CHAR_PAD;
        8: begin
          drop = $urandom_range(1, 3);
          repeat (drop) text.pop_back();
          if (text.size() == 0) text.insert(0, alphabet_char($urandom_range(0, 63)));
        end
        default: ;
      endcase
    end
    send_text(text);
  endtask

  function automatic void add_row(input logic [7:0] c, input logic last,
                                  input row_kind_t kind, input beat_t b);
    char_row_t r;
    r.ch   = c;
    r.last = last;
    r.kind = kind;
    r.beat = b;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // reader side
  initial begin
    int gap;
    int spell;
    bit quiet;
    out_pop = 1'b0;
    spell   = 0;
    quiet   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (spell == 0) begin
        spell = 32;
        quiet = ($urandom_range(0, 3) == 0);
      end
      spell--;
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: data_byte %h text_done %b", out_data_byte, out_text_done);
        mismatches++;
      end else begin
        head_beat = expected_beats.pop_front();
        if (out_data_byte !== head_beat.data_byte) begin
          $error("data_byte: expected %h, got %h", head_beat.data_byte, out_data_byte);
          mismatches++;
        end
        if (out_byte_valid !== head_beat.byte_valid) begin
          $error("byte_valid: expected %b, got %b", head_beat.byte_valid, out_byte_valid);
          mismatches++;
        end
        if (out_run_last !== head_beat.run_last) begin
          $error("run_last: expected %b, got %b", head_beat.run_last, out_run_last);
          mismatches++;
        end
        if (out_text_done !== head_beat.text_done) begin
          $error("text_done: expected %b, got %b", head_beat.text_done, out_text_done);
          mismatches++;
        end
        if (out_failed !== head_beat.failed) begin
          $error("failed: expected %b, got %b", head_beat.failed, out_failed);
          mismatches++;
        end
      end
    end
  end

  // writer side and run control
  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_text_char = '0;
    in_text_last = 1'b0;
    quad_pos     = '0;
    sextet_acc   = '0;
    third_is_pad = 1'b0;
    text_error   = 1'b0;
    chars_sent   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    sender_idles = 1'b1;

    // padding with nonzero bits underneath
    add_row("Q", 1'b0, ROW_QUIET, NO_BEAT);
    add_row("R", 1'b0, ROW_QUIET, NO_BEAT);
    add_row(CHAR_PAD, 1'b0, ROW_QUIET, NO_BEAT);
    add_row(CHAR_PAD, 1'b1, ROW_ONE, '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0});
    // all-zero and all-one quads
    repeat (4) add_row("A", 1'b0, ROW_PREDICTED, NO_BEAT);
    repeat (3) add_row(CHAR_SLASH, 1'b0, ROW_PREDICTED, NO_BEAT);
    add_row(CHAR_SLASH, 1'b1, ROW_PREDICTED, NO_BEAT);
    // invalid byte
    add_row(8'hFF, 1'b1, ROW_ONE, FAIL_BEAT);
    // pad in first position, then a zero byte ignored
    add_row(CHAR_PAD, 1'b0, ROW_QUIET, NO_BEAT);
    add_row(8'h00, 1'b1, ROW_ONE, FAIL_BEAT);
    // pad at third without pad at fourth
    add_row(CHAR_PLUS, 1'b0, ROW_QUIET, NO_BEAT);
    add_row("B", 1'b0, ROW_QUIET, NO_BEAT);
    add_row(CHAR_PAD, 1'b0, ROW_QUIET, NO_BEAT);
    add_row("C", 1'b1, ROW_ONE, FAIL_BEAT);
    // padded quad in the middle of a text
    add_row("Z", 1'b0, ROW_QUIET, NO_BEAT);
    add_row("m", 1'b0, ROW_QUIET, NO_BEAT);
    add_row("9", 1'b0, ROW_QUIET, NO_BEAT);
    add_row(CHAR_PAD, 1'b0, ROW_QUIET, NO_BEAT);
    add_row("A", 1'b1, ROW_ONE, FAIL_BEAT);
    // length not a multiple of four
    add_row("9", 1'b0, ROW_QUIET, NO_BEAT);
    add_row(CHAR_PLUS, 1'b1, ROW_ONE, FAIL_BEAT);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].last);
      decode_step(directed_rows[i].ch, directed_rows[i].last,
                  directed_rows[i].kind == ROW_PREDICTED);
      if (directed_rows[i].kind == ROW_ONE) queue_beat(directed_rows[i].beat);
    end

    hold_request = 1'b1;
    chars_sent   = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= CALM_AFTER) calm = 1'b1;
      send_random_text();
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
